### rtl/core/c2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c2d_pkg;

    // operation codes of an input beat
    localparam logic [1:0] MODE_PIXEL   = 2'd0;
    localparam logic [1:0] MODE_WEIGHT  = 2'd1;
    localparam logic [1:0] MODE_BIAS    = 2'd2;
    localparam logic [1:0] MODE_COMPUTE = 2'd3;

    // configuration register indexes
    localparam logic [3:0] REG_IN_CH  = 4'd0;
    localparam logic [3:0] REG_OUT_CH = 4'd1;
    localparam logic [3:0] REG_IN_H   = 4'd2;
    localparam logic [3:0] REG_IN_W   = 4'd3;
    localparam logic [3:0] REG_K_H    = 4'd4;
    localparam logic [3:0] REG_K_W    = 4'd5;
    localparam logic [3:0] REG_STEP   = 4'd6;
    localparam logic [3:0] REG_PAD    = 4'd7;

    // internal address widths, sized for the largest legal store
    localparam int PA_W = 26;
    localparam int WA_W = 20;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SET1  = 6'b000010,
        ST_SET2  = 6'b000100,
        ST_SET3  = 6'b001000,
        ST_RUN   = 6'b010000,
        ST_DRAIN = 6'b100000
    } t_state;

endpackage
`default_nettype wire

### rtl/core/conv2d_direct_forward_top.sv
// Load beats (pixel, weight, bias) finish in IDLE; busy stays low.
// A compute beat runs through SET1, SET2, SET3, RUN and DRAIN up to the o_done strobe;
// a flagged position ends in SET2. Taps pass through one multiply-add unit.
// One item at a time: busy is high from acceptance until the result strobe.
// Synchronous active-low reset clears control and the bias valid flags and loads default settings.
// The result is shown for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_direct_forward_top
    import c2d_pkg::*;
#(
    parameter int MAX_IN_CHANNELS  = 16,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int MAX_HEIGHT       = 32,
    parameter int MAX_WIDTH        = 32,
    parameter int MAX_KERNEL       = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_mode,
    input  wire logic [13:0]        i_address,
    input  wire logic signed [15:0] i_value,
    input  wire logic [3:0]         i_out_channel,
    input  wire logic [4:0]         i_out_row,
    input  wire logic [4:0]         i_out_col,
    output logic                    o_done,
    output logic signed [47:0]      o_sum,
    output logic                    o_out_of_range,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [5:0]         i_cfg_data
);

    localparam int PIX_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int PAW = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BAW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    // configuration registers
    logic [4:0] r_cin, r_cout;
    logic [5:0] r_h, r_w;
    logic [2:0] r_kh, r_kw, r_s;
    logic [1:0] r_p;

    // effective (saturated) settings
    logic [6:0] c_cin, c_cout;
    logic [8:0] c_h, c_w;
    logic [3:0] c_kh, c_kw;
    logic [2:0] c_s;

    t_state r_state;

    logic [3:0]  r_co;
    logic [4:0]  r_row, r_col;
    logic [7:0]  r_khkw;
    logic [17:0] r_hw;
    logic signed [9:0] r_y0, r_x0;
    logic        r_oor;
    logic [14:0] r_cinkk;
    logic signed [PA_W-1:0] r_y0w;
    logic [WA_W-1:0] r_wa;
    logic signed [PA_W-1:0] r_pa_chan, r_pa_row;
    logic [6:0]  r_ci;
    logic [3:0]  r_a, r_b;

    logic signed [15:0] pix_mem [PIX_DEPTH];
    logic signed [15:0] wgt_mem [WGT_DEPTH];
    logic signed [15:0] bias_mem [MAX_OUT_CHANNELS];
    logic [MAX_OUT_CHANNELS-1:0] r_bvld;

    logic signed [15:0] r_bias_q, r_pix_q, r_wgt_q;
    logic        r_bias_ok;
    logic        r_rd_v, r_prd_v;
    logic signed [31:0] r_prd;
    logic signed [47:0] r_acc;

    logic        accept;
    logic signed [9:0] y_cur, x_cur;
    logic        tap_ok;
    logic signed [PA_W-1:0] pa_cur;
    logic        last_b, last_a, last_ci;
    logic [9:0]  row_span, col_span, h_span, w_span;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // saturate registers to their legal ranges
    always_comb begin
        c_cin  = (r_cin == 5'd0) ? 7'd1 :
                 (7'(r_cin) > 7'(MAX_IN_CHANNELS)) ? 7'(MAX_IN_CHANNELS) : 7'(r_cin);
        c_cout = (r_cout == 5'd0) ? 7'd1 :
                 (7'(r_cout) > 7'(MAX_OUT_CHANNELS)) ? 7'(MAX_OUT_CHANNELS) : 7'(r_cout);
        c_h    = (r_h == 6'd0) ? 9'd1 :
                 (9'(r_h) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(r_h);
        c_w    = (r_w == 6'd0) ? 9'd1 :
                 (9'(r_w) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(r_w);
        c_kh   = (r_kh == 3'd0) ? 4'd1 :
                 (4'(r_kh) > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : 4'(r_kh);
        c_kw   = (r_kw == 3'd0) ? 4'd1 :
                 (4'(r_kw) > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : 4'(r_kw);
        c_s    = (r_s == 3'd0) ? 3'd1 : (r_s > 3'd4) ? 3'd4 : r_s;
    end

    // output range test: row*s + kH must fit in H + 2p
    always_comb begin
        row_span = 10'(r_row * c_s) + 10'(c_kh);
        col_span = 10'(r_col * c_s) + 10'(c_kw);
        h_span   = 10'(c_h) + 10'({r_p, 1'b0});
        w_span   = 10'(c_w) + 10'({r_p, 1'b0});
    end

    // current tap position and its pixel address
    always_comb begin
        y_cur   = r_y0 + $signed({6'd0, r_a});
        x_cur   = r_x0 + $signed({6'd0, r_b});
        tap_ok  = (y_cur >= 0) && (y_cur < $signed({1'b0, c_h}))
               && (x_cur >= 0) && (x_cur < $signed({1'b0, c_w}));
        pa_cur  = r_pa_row + $signed({{(PA_W-4){1'b0}}, r_b});
        last_b  = (r_b == c_kw - 4'd1);
        last_a  = (r_a == c_kh - 4'd1);
        last_ci = (r_ci == c_cin - 7'd1);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cin  <= 5'd1;
            r_cout <= 5'd1;
            r_h    <= 6'd32;
            r_w    <= 6'd32;
            r_kh   <= 3'd3;
            r_kw   <= 3'd3;
            r_s    <= 3'd1;
            r_p    <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IN_CH:  r_cin  <= i_cfg_data[4:0];
                REG_OUT_CH: r_cout <= i_cfg_data[4:0];
                REG_IN_H:   r_h    <= i_cfg_data;
                REG_IN_W:   r_w    <= i_cfg_data;
                REG_K_H:    r_kh   <= i_cfg_data[2:0];
                REG_K_W:    r_kw   <= i_cfg_data[2:0];
                REG_STEP:   r_s    <= i_cfg_data[2:0];
                REG_PAD:    r_p    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // store loads
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_PIXEL && 32'(i_address) < PIX_DEPTH) begin
            pix_mem[PAW'(i_address)] <= i_value;
        end
        if (accept && i_mode == MODE_WEIGHT && 32'(i_address) < WGT_DEPTH) begin
            wgt_mem[WAW'(i_address)] <= i_value;
        end
        if (accept && i_mode == MODE_BIAS && 32'(i_address) < MAX_OUT_CHANNELS) begin
            bias_mem[BAW'(i_address)] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else if (accept && i_mode == MODE_BIAS && 32'(i_address) < MAX_OUT_CHANNELS) begin
            r_bvld[BAW'(i_address)] <= 1'b1;
        end
    end

    // store reads, registered
    always_ff @(posedge i_clk) begin
        r_bias_q  <= bias_mem[BAW'(r_co)];
        r_bias_ok <= r_bvld[BAW'(r_co)];
        r_pix_q   <= pix_mem[pa_cur[PAW-1:0]];
        r_wgt_q   <= wgt_mem[r_wa[WAW-1:0]];
        r_prd     <= r_pix_q * r_wgt_q;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_rd_v         <= 1'b0;
            r_prd_v        <= 1'b0;
            o_done         <= 1'b0;
            o_sum          <= '0;
            o_out_of_range <= 1'b0;
        end else begin
            o_done  <= 1'b0;
            r_rd_v  <= (r_state == ST_RUN) && tap_ok;
            r_prd_v <= r_rd_v;
            if (r_prd_v) begin
                r_acc <= r_acc + {{16{r_prd[31]}}, r_prd};
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_mode == MODE_COMPUTE) begin
                        r_co    <= i_out_channel;
                        r_row   <= i_out_row;
                        r_col   <= i_out_col;
                        r_state <= ST_SET1;
                    end
                end
                // geometry products and the range test
                ST_SET1: begin
                    r_khkw  <= 8'(c_kh * c_kw);
                    r_hw    <= 18'(c_h * c_w);
                    r_y0    <= $signed(10'(r_row * c_s) - 10'(r_p));
                    r_x0    <= $signed(10'(r_col * c_s) - 10'(r_p));
                    r_oor   <= (7'(r_co) >= c_cout) || (row_span > h_span)
                            || (col_span > w_span);
                    r_state <= ST_SET2;
                end
                // flagged item ends here; else seed the sum with the bias shifted left by 8
                ST_SET2: begin
                    r_cinkk <= 15'(c_cin * r_khkw);
                    r_y0w   <= PA_W'(r_y0 * $signed({1'b0, c_w}));
                    r_acc   <= r_bias_ok ? (48'(r_bias_q) <<< 8) : '0;
                    if (r_oor) begin
                        o_done         <= 1'b1;
                        o_sum          <= '0;
                        o_out_of_range <= 1'b1;
                        r_state        <= ST_IDLE;
                    end else begin
                        r_state <= ST_SET3;
                    end
                end
                ST_SET3: begin
                    r_wa      <= WA_W'(r_co * r_cinkk);
                    r_pa_chan <= r_y0w + PA_W'(r_x0);
                    r_pa_row  <= r_y0w + PA_W'(r_x0);
                    r_ci      <= '0;
                    r_a       <= '0;
                    r_b       <= '0;
                    r_state   <= ST_RUN;
                end
                // one tap per cycle through the shared multiply-add
                ST_RUN: begin
                    r_wa <= r_wa + 1'b1;
                    if (!last_b) begin
                        r_b <= r_b + 4'd1;
                    end else if (!last_a) begin
                        r_b      <= '0;
                        r_a      <= r_a + 4'd1;
                        r_pa_row <= r_pa_row + PA_W'(c_w);
                    end else if (!last_ci) begin
                        r_b       <= '0;
                        r_a       <= '0;
                        r_ci      <= r_ci + 7'd1;
                        r_pa_chan <= r_pa_chan + PA_W'(r_hw);
                        r_pa_row  <= r_pa_chan + PA_W'(r_hw);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                // let the read and multiply stages empty
                ST_DRAIN: begin
                    if (!r_rd_v && !r_prd_v) begin
                        o_done         <= 1'b1;
                        o_sum          <= r_acc;
                        o_out_of_range <= 1'b0;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out_of_range |-> o_sum == '0) else $error("flagged sum not zero");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == ST_IDLE) else $error("strobe while busy");
    a_ci_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_ci < c_cin) else $error("channel count overrun");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import c2d_pkg::*;

    localparam int       CYCLE_LIMIT = 4_000_000;
    localparam int       PIX_DEPTH   = 16384;
    localparam int       WGT_DEPTH   = 12544;
    localparam logic [3:0] REG_UNUSED = 4'd9;

    typedef struct packed {
        logic signed [47:0] sum;
        logic               oor;
    } t_conv_result;

    // predicts convolution results and matches them against the block
    class conv_scoreboard;
        logic signed [15:0] pixels [PIX_DEPTH];
        logic signed [15:0] weights [WGT_DEPTH];
        logic signed [15:0] biases [16];
        bit [5:0]           regs [8];
        t_conv_result       expected_q [$];
        int                 errors;

        function new();
            foreach (pixels[i]) pixels[i] = '0;
            foreach (weights[i]) weights[i] = '0;
            foreach (biases[i]) biases[i] = '0;
            regs = '{6'd1, 6'd1, 6'd32, 6'd32, 6'd3, 6'd3, 6'd1, 6'd0};
            errors = 0;
        endfunction

        function int reg_val(int idx, int lo, int hi);
            if (int'(regs[idx]) < lo) return lo;
            if (int'(regs[idx]) > hi) return hi;
            return int'(regs[idx]);
        endfunction

        function int n_cin();  return reg_val(REG_IN_CH, 1, 16);  endfunction
        function int n_cout(); return reg_val(REG_OUT_CH, 1, 16); endfunction
        function int n_h();    return reg_val(REG_IN_H, 1, 32);   endfunction
        function int n_w();    return reg_val(REG_IN_W, 1, 32);   endfunction
        function int n_kh();   return reg_val(REG_K_H, 1, 7);     endfunction
        function int n_kw();   return reg_val(REG_K_W, 1, 7);     endfunction
        function int n_step(); return reg_val(REG_STEP, 1, 4);    endfunction
        function int n_pad();  return reg_val(REG_PAD, 0, 3);     endfunction

        function int out_dim(int extent, int k);
            int span;
            span = extent + 2 * n_pad();
            if (span < k) return 0;
            return (span - k) / n_step() + 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [3:0] idx, logic [5:0] data);
            bit [5:0] mask;
            if (idx > REG_PAD) return;
            case (idx)
                REG_IN_CH, REG_OUT_CH: mask = 6'h1f;
                REG_IN_H, REG_IN_W:    mask = 6'h3f;
                REG_PAD:               mask = 6'h03;
                default:               mask = 6'h07;
            endcase
            regs[idx] = data & mask;
        endfunction

        // update the stores on a load beat, or queue the result of a compute beat
        function void note_input(logic [1:0] mode, logic [13:0] addr, logic signed [15:0] val,
                                 logic [3:0] co, logic [4:0] row, logic [4:0] col);
            t_conv_result r;
            longint       acc;
            int           y, x, pi, wi;
            case (mode)
                MODE_PIXEL:  if (addr < PIX_DEPTH) pixels[addr] = val;
                MODE_WEIGHT: if (addr < WGT_DEPTH) weights[addr] = val;
                MODE_BIAS:   if (addr < 16) biases[addr] = val;
                default: begin
                    r.sum = '0;
                    r.oor = 1'b1;
                    if (co < n_cout() && row < out_dim(n_h(), n_kh())
                        && col < out_dim(n_w(), n_kw())) begin
                        acc = longint'(biases[co]) * 256;
                        for (int c = 0; c < n_cin(); c++)
                            for (int a = 0; a < n_kh(); a++)
                                for (int b = 0; b < n_kw(); b++) begin
                                    y = int'(row) * n_step() - n_pad() + a;
                                    x = int'(col) * n_step() - n_pad() + b;
                                    if (y >= 0 && y < n_h() && x >= 0 && x < n_w()) begin
                                        pi = c * n_h() * n_w() + y * n_w() + x;
                                        wi = int'(co) * n_cin() * n_kh() * n_kw()
                                             + c * n_kh() * n_kw() + a * n_kw() + b;
                                        acc += longint'(int'(pixels[pi]) * int'(weights[wi]));
                                    end
                                end
                        r.sum = acc[47:0];
                        r.oor = 1'b0;
                    end
                    expected_q = {expected_q, r};
                end
            endcase
        endfunction

        function void check_result(logic signed [47:0] sum, logic oor);
            t_conv_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result: sum %0d out_of_range %0b", sum, oor);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (sum !== e.sum) begin
                $error("sum: expected %0d, actual %0d", e.sum, sum);
                errors++;
            end
            if (oor !== e.oor) begin
                $error("out_of_range: expected %0b, actual %0b", e.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = '0;
    logic [13:0]        i_address = '0;
    logic signed [15:0] i_value = '0;
    logic [3:0]         i_out_channel = '0;
    logic [4:0]         i_out_row = '0;
    logic [4:0]         i_out_col = '0;
    logic               o_done;
    logic signed [47:0] o_sum;
    logic               o_out_of_range;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index = '0;
    logic [5:0]         i_cfg_data = '0;

    conv_scoreboard sb = new();
    int             idle_pct = 0;
    int             cycles = 0;

    conv2d_direct_forward_top uut (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_address, .i_value,
        .i_out_channel, .i_out_row, .i_out_col, .o_done, .o_sum, .o_out_of_range,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    // bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // check every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_sum, o_out_of_range);
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // drive one beat, called at a falling edge; returns at a falling edge
    task automatic send_beat(logic [1:0] mode, logic [13:0] addr, logic [15:0] val,
                             logic [3:0] co, logic [4:0] row, logic [4:0] col);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            i_address = 14'($urandom);
            i_value = 16'($urandom);
            @(negedge i_clk);
        end
        start = 1'b1;
        i_mode = mode;
        i_address = addr;
        i_value = val;
        i_out_channel = co;
        i_out_row = row;
        i_out_col = col;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_input(mode, addr, val, co, row, col);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic load(logic [1:0] mode, int addr, logic [15:0] val);
        send_beat(mode, 14'(addr), val, 4'($urandom), 5'($urandom), 5'($urandom));
    endtask

    task automatic compute(int co, int row, int col);
        send_beat(MODE_COMPUTE, 14'($urandom), 16'($urandom), 4'(co), 5'(row), 5'(col));
    endtask

    task automatic write_cfg(logic [3:0] idx, logic [5:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold until every result is in and the block has settled
    task automatic wait_idle();
        while (sb.pending() > 0 || busy) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // configure when asked, fill the stores in the active range, then random beats
    task automatic run_phase(int cfg[8], bit do_cfg, int n_rand, int pct);
        int n_pix, n_wgt, hout, wout, counted, r;
        idle_pct = pct;
        if (do_cfg) begin
            wait_idle();
            for (int i = 0; i < 8; i++) write_cfg(4'(i), 6'(cfg[i]));
        end
        n_pix = sb.n_cin() * sb.n_h() * sb.n_w();
        n_wgt = sb.n_cout() * sb.n_cin() * sb.n_kh() * sb.n_kw();
        hout = sb.out_dim(sb.n_h(), sb.n_kh());
        wout = sb.out_dim(sb.n_w(), sb.n_kw());
        for (int a = 0; a < n_pix; a++) load(MODE_PIXEL, a, pick_value());
        for (int a = 0; a < n_wgt; a++) load(MODE_WEIGHT, a, pick_value());
        for (int a = 0; a < sb.n_cout(); a++) load(MODE_BIAS, a, pick_value());
        counted = 0;
        while (counted < n_rand) begin
            r = $urandom_range(99);
            if (r < 55) begin
                compute(($urandom_range(9) == 0) ? $urandom_range(15)
                                                 : $urandom_range(sb.n_cout() - 1),
                        ($urandom_range(7) == 0 || hout == 0) ? $urandom_range(31)
                                                              : $urandom_range(hout - 1),
                        ($urandom_range(7) == 0 || wout == 0) ? $urandom_range(31)
                                                              : $urandom_range(wout - 1));
                counted++;
            end else if (r < 70) begin
                load(MODE_PIXEL, $urandom_range(n_pix - 1), pick_value());
                counted++;
            end else if (r < 82) begin
                load(MODE_WEIGHT, $urandom_range(n_wgt - 1), pick_value());
                counted++;
            end else if (r < 93) begin
                load(MODE_BIAS, $urandom_range(15), pick_value());
                counted++;
            end else if (r < 96) begin
                // drop: address past the weight store
                load(MODE_WEIGHT, $urandom_range(WGT_DEPTH, 16383), pick_value());
            end else begin
                load(MODE_BIAS, $urandom_range(16, 16383), pick_value());
            end
        end
    endtask

    initial begin
        int none[8];
        none = '{0, 0, 0, 0, 0, 0, 0, 0};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset setting: 1 channel, 32x32 image, 3x3 kernel
        run_phase(none, 1'b0, 0, 0);
        load(MODE_BIAS, 0, 16'h7fff);
        load(MODE_BIAS, 16, 16'h1234);
        load(MODE_WEIGHT, WGT_DEPTH, 16'h4321);
        load(MODE_WEIGHT, 16383, 16'hffff);
        load(MODE_PIXEL, 16383, 16'h8000);
        load(MODE_PIXEL, 0, 16'h8000);
        load(MODE_WEIGHT, 0, 16'h8000);
        compute(0, 0, 0);
        compute(0, 29, 29);
        compute(0, 30, 0);
        compute(0, 0, 30);
        compute(1, 0, 0);
        compute(15, 31, 31);
        load(MODE_BIAS, 0, 16'h8000);
        load(MODE_PIXEL, 1023, 16'h7fff);
        load(MODE_WEIGHT, 8, 16'h7fff);
        compute(0, 29, 29);
        compute(0, 0, 0);
        run_phase(none, 1'b0, 60, 0);

        run_phase('{2, 3, 5, 6, 3, 2, 1, 1}, 1'b1, 80, 70);
        run_phase('{16, 16, 32, 32, 7, 7, 4, 3}, 1'b1, 30, 0);
        run_phase('{1, 1, 1, 1, 1, 1, 1, 0}, 1'b1, 60, 35);
        run_phase('{3, 2, 4, 4, 7, 7, 2, 3}, 1'b1, 80, 0);
        // kernel larger than the padded image: every position flagged
        run_phase('{2, 2, 2, 2, 7, 7, 1, 0}, 1'b1, 40, 70);
        // out-of-range register values saturate; unknown index is dropped
        wait_idle();
        write_cfg(REG_UNUSED, 6'd5);
        run_phase('{0, 31, 63, 0, 0, 7, 7, 63}, 1'b1, 80, 35);
        run_phase('{4, 5, 9, 7, 5, 3, 3, 2}, 1'b1, 80, 70);

        while (sb.pending() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
